@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on clk, off during reset
`define FFG_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication on clk, off during reset
`define FFG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/ffg_pkg.sv @@
// shared types, constants and helpers of the forest fire grid step block
package ffg_pkg;

  localparam int GRID_W  = 128;
  localparam int GRID_H  = 128;
  localparam int CELL_N  = GRID_W * GRID_H;
  localparam int CELL_AW = $clog2(CELL_N);
  localparam int XW      = $clog2(GRID_W);
  localparam int YW      = $clog2(GRID_H);
  localparam int CNT_W   = CELL_AW + 1;
  localparam int DIVD_W  = 33;

  localparam logic [0:0]  REG_MATCH  = 1'd0;
  localparam logic [0:0]  REG_WARMUP = 1'd1;
  localparam logic [15:0] MATCH_RST  = 16'd2000;
  localparam logic [15:0] WARMUP_RST = 16'd128;

  typedef struct packed {
    logic [YW-1:0] y;
    logic [XW-1:0] x;
  } coord_t;

  typedef struct packed {
    logic [6:0] plant_x;
    logic [6:0] plant_y;
    logic [6:0] spark_x;
    logic [6:0] spark_y;
  } in_item_t;

  typedef struct packed {
    logic [31:0] step_index;
    logic        tree_planted;
    logic        spark_thrown;
    logic        fire_started;
    logic [14:0] fire_size;
    logic [31:0] fires_total;
    logic [31:0] burned_total;
  } out_item_t;

  function automatic logic [CELL_AW-1:0] cell_idx(input coord_t c);
    cell_idx = CELL_AW'(int'(c.y) * GRID_W + int'(c.x));
  endfunction

endpackage

@@ rtl/core/ffg_ram.sv @@
// generic single-write, single-read ram with registered read data
module ffg_ram #(
  parameter int DW = 8,
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/ffg_mod_unit.sv @@
// bit-serial restoring remainder unit, one dividend bit per cycle
module ffg_mod_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ffg_pkg::DIVD_W-1:0] dividend,
  input  logic [15:0]                divisor,
  output logic                       done,
  output logic [15:0]                rem
);

  logic [ffg_pkg::DIVD_W-1:0] q_r;
  logic [15:0]                rem_r;
  logic [5:0]                 cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [16:0]                trial;

  assign trial = {rem_r, q_r[ffg_pkg::DIVD_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r    <= dividend;
        rem_r  <= '0;
        cnt_r  <= 6'(ffg_pkg::DIVD_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (trial >= {1'b0, divisor}) begin
          rem_r <= 16'(trial - {1'b0, divisor});
        end else begin
          rem_r <= 16'(trial);
        end
        q_r   <= q_r << 1;
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

@@ rtl/core/forest_fire_grid_step.sv @@
// forest fire grid step: plant, spark test and stack-based cluster burn
// steps run one at a time, each opening with the serial remainder; start is taken only while busy is low
// reset: a clearing pass zeroes the grid ram, busy stays high
// results are strobed for one cycle on out_valid; the receiver cannot stall
`include "assert_macros.svh"

module forest_fire_grid_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ffg_pkg::in_item_t  in_data,
  output logic               out_valid,
  output ffg_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_idx,
  input  logic [15:0]        cfg_data
);

  typedef enum logic [11:0] {
    S_CLEAR     = 12'b000000000001,
    S_IDLE      = 12'b000000000010,
    S_DIV       = 12'b000000000100,
    S_PLANT_RD  = 12'b000000001000,
    S_PLANT_WR  = 12'b000000010000,
    S_SPARK_RD  = 12'b000000100000,
    S_SPARK_CHK = 12'b000001000000,
    S_POP       = 12'b000010000000,
    S_POP_WAIT  = 12'b000100000000,
    S_NB        = 12'b001000000000,
    S_NB_CHK    = 12'b010000000000,
    S_DONE      = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  ffg_pkg::in_item_t  in_r;
  ffg_pkg::out_item_t out_r;
  logic               out_valid_r;
  logic [31:0]        step_r, fires_r, burned_r;
  logic [15:0]        interval_r, warmup_r;
  logic               spark_r, planted_r, fire_r;
  logic [ffg_pkg::CNT_W-1:0]   count_r, top_r;
  logic [ffg_pkg::CELL_AW-1:0] clr_r;
  ffg_pkg::coord_t    cur_r;
  logic [1:0]         k_r;

  logic               mod_done;
  logic [15:0]        mod_rem;
  logic               mod_start;

  logic               plant_ok, spark_ok;
  ffg_pkg::coord_t    plant_c, spark_c, nb;
  logic               nb_ok;

  logic                        g_we, g_wdata, g_rdata;
  logic [ffg_pkg::CELL_AW-1:0] g_waddr, g_raddr;
  logic                        s_we;
  logic [ffg_pkg::CELL_AW-1:0] s_waddr, s_raddr;
  ffg_pkg::coord_t             s_wdata, s_rdata;
  logic [ffg_pkg::CNT_W-1:0]   top_m1;
  logic [31:0]                 fires_new, burned_new;

  assign busy      = (state_r != S_IDLE);
  assign mod_start = (state_r == S_IDLE) && start;

  ffg_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend ({1'b0, step_r} + 33'd1),
    .divisor  (interval_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  ffg_ram #(.DW(1), .AW(ffg_pkg::CELL_AW)) u_grid (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  ffg_ram #(.DW($bits(ffg_pkg::coord_t)), .AW(ffg_pkg::CELL_AW)) u_stack (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  assign plant_ok  = (int'(in_r.plant_x) < ffg_pkg::GRID_W) &&
                     (int'(in_r.plant_y) < ffg_pkg::GRID_H);
  assign spark_ok  = (int'(in_r.spark_x) < ffg_pkg::GRID_W) &&
                     (int'(in_r.spark_y) < ffg_pkg::GRID_H);
  assign plant_c.x = ffg_pkg::XW'(in_r.plant_x);
  assign plant_c.y = ffg_pkg::YW'(in_r.plant_y);
  assign spark_c.x = ffg_pkg::XW'(in_r.spark_x);
  assign spark_c.y = ffg_pkg::YW'(in_r.spark_y);
  assign top_m1    = top_r - 1'b1;

  // neighbor probe k: left, right, up, down
  always_comb begin
    nb    = cur_r;
    nb_ok = 1'b0;
    unique case (k_r)
      2'd0: begin
        if (cur_r.x != '0) begin
          nb.x  = cur_r.x - 1'b1;
          nb_ok = 1'b1;
        end
      end
      2'd1: begin
        if (int'(cur_r.x) + 1 < ffg_pkg::GRID_W) begin
          nb.x  = cur_r.x + 1'b1;
          nb_ok = 1'b1;
        end
      end
      2'd2: begin
        if (cur_r.y != '0) begin
          nb.y  = cur_r.y - 1'b1;
          nb_ok = 1'b1;
        end
      end
      default: begin
        if (int'(cur_r.y) + 1 < ffg_pkg::GRID_H) begin
          nb.y  = cur_r.y + 1'b1;
          nb_ok = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    g_we    = 1'b0;
    g_waddr = clr_r;
    g_wdata = 1'b0;
    g_raddr = ffg_pkg::cell_idx(nb);
    s_we    = 1'b0;
    s_waddr = top_r[ffg_pkg::CELL_AW-1:0];
    s_wdata = nb;
    s_raddr = top_m1[ffg_pkg::CELL_AW-1:0];
    unique case (state_r)
      S_CLEAR: begin
        g_we = 1'b1;
      end
      S_PLANT_RD: begin
        g_raddr = ffg_pkg::cell_idx(plant_c);
      end
      S_PLANT_WR: begin
        g_waddr = ffg_pkg::cell_idx(plant_c);
        g_wdata = 1'b1;
        g_we    = plant_ok && !g_rdata;
      end
      S_SPARK_RD: begin
        g_raddr = ffg_pkg::cell_idx(spark_c);
      end
      S_SPARK_CHK: begin
        g_waddr = ffg_pkg::cell_idx(spark_c);
        g_we    = spark_r && spark_ok && g_rdata;
        s_we    = spark_r && spark_ok && g_rdata;
        s_wdata = spark_c;
      end
      S_NB_CHK: begin
        g_waddr = ffg_pkg::cell_idx(nb);
        g_we    = g_rdata;
        s_we    = g_rdata;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_r == ffg_pkg::CELL_AW'(ffg_pkg::CELL_N - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_nxt = S_DIV;
      end
      S_DIV: begin
        if (mod_done) state_nxt = S_PLANT_RD;
      end
      S_PLANT_RD:  state_nxt = S_PLANT_WR;
      S_PLANT_WR:  state_nxt = S_SPARK_RD;
      S_SPARK_RD:  state_nxt = S_SPARK_CHK;
      S_SPARK_CHK: begin
        state_nxt = (spark_r && spark_ok && g_rdata) ? S_POP : S_DONE;
      end
      S_POP: begin
        state_nxt = (top_r == '0) ? S_DONE : S_POP_WAIT;
      end
      S_POP_WAIT: state_nxt = S_NB;
      S_NB: begin
        if (nb_ok) state_nxt = S_NB_CHK;
        else if (k_r == 2'd3) state_nxt = S_POP;
      end
      S_NB_CHK: begin
        state_nxt = (k_r == 2'd3) ? S_POP : S_NB;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  assign fires_new  = fires_r + 32'(fire_r);
  assign burned_new = burned_r + 32'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      fires_r     <= '0;
      burned_r    <= '0;
      interval_r  <= ffg_pkg::MATCH_RST;
      warmup_r    <= ffg_pkg::WARMUP_RST;
      top_r       <= '0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_idx)
          ffg_pkg::REG_MATCH:  interval_r <= cfg_data;
          ffg_pkg::REG_WARMUP: warmup_r   <= cfg_data;
          default: begin
          end
        endcase
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
        end
        S_IDLE: begin
          if (start) begin
            in_r      <= in_data;
            planted_r <= 1'b0;
            fire_r    <= 1'b0;
            count_r   <= '0;
            top_r     <= '0;
          end
        end
        S_DIV: begin
          if (mod_done) begin
            spark_r <= (interval_r != '0) && (mod_rem == '0) &&
                       (step_r > {16'd0, warmup_r});
          end
        end
        S_PLANT_WR: begin
          planted_r <= plant_ok && !g_rdata;
        end
        S_SPARK_CHK: begin
          if (spark_r && spark_ok && g_rdata) begin
            fire_r  <= 1'b1;
            count_r <= ffg_pkg::CNT_W'(1);
            top_r   <= ffg_pkg::CNT_W'(1);
          end
        end
        S_POP: begin
          if (top_r != '0) top_r <= top_m1;
        end
        S_POP_WAIT: begin
          cur_r <= s_rdata;
          k_r   <= '0;
        end
        S_NB: begin
          if (!nb_ok) k_r <= k_r + 2'd1;
        end
        S_NB_CHK: begin
          if (g_rdata) begin
            top_r   <= top_r + 1'b1;
            count_r <= count_r + 1'b1;
          end
          k_r <= k_r + 2'd1;
        end
        S_DONE: begin
          fires_r                <= fires_new;
          burned_r               <= burned_new;
          step_r                 <= step_r + 32'd1;
          out_valid_r            <= 1'b1;
          out_r.step_index       <= step_r;
          out_r.tree_planted     <= planted_r;
          out_r.spark_thrown     <= spark_r;
          out_r.fire_started     <= fire_r;
          out_r.fire_size        <= (32'(count_r) > 32'd32767) ? 15'h7fff : 15'(count_r);
          out_r.fires_total      <= fires_new;
          out_r.burned_total     <= burned_new;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `FFG_ASSERT_NEXT(a_one_beat, out_valid_r, !out_valid_r)
  `FFG_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `FFG_ASSERT_SAME(a_fire_needs_spark, out_valid_r, !out_r.fire_started || out_r.spark_thrown)
  `FFG_ASSERT_SAME(a_stack_bound, 1'b1, 32'(top_r) <= 32'(ffg_pkg::CELL_N))

endmodule
